FILE: rtl/core/c2p_pkg.sv
// Shared constants, codes and types of the chunky-to-planar converter.
package c2p_pkg;

  // Store and image geometry
  localparam int STORE_PIXELS = 131072;
  localparam int MAX_PLANES   = 8;
  localparam int SPRITE_WIDTH = 64;
  localparam int WORD_BITS    = 32;

  localparam int STORE_AW  = $clog2(STORE_PIXELS);
  localparam int LOAD_CW   = $clog2(STORE_PIXELS + 1);
  localparam int BIT_IDX_W = $clog2(WORD_BITS);
  localparam int GATHER_CW = $clog2(WORD_BITS + 1);

  // Field and register widths
  localparam int MODE_W     = 2;
  localparam int PLANES_W   = 4;
  localparam int WIDTH_W    = 6;
  localparam int HEIGHT_W   = 11;
  localparam int PIXEL_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int TOTAL_W    = WIDTH_W + HEIGHT_W + BIT_IDX_W;

  // Position counter widths
  localparam int PLANE_W = 3;
  localparam int ROW_W   = 11;
  localparam int WCNT_W  = 5;
  localparam int COL_W   = 4;

  // Sprite framing: blank words at head and tail, words per sprite row
  localparam int EDGE_WORDS       = (8 * 2) / 4;
  localparam int SPRITE_ROW_WORDS = SPRITE_WIDTH / WORD_BITS;
  localparam int BODY_ROW_WORDS   = 2 * SPRITE_ROW_WORDS;

  // Output modes
  localparam logic [MODE_W-1:0] MODE_PLANES = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

  // Request codes on the input beat
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_LOAD_INCOMPLETE,
    ST_BAD_GEOMETRY
  } status_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_BODY,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FETCH,
    CMD_FETCH_BAD
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_GATHER
  } back_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PLANES_W-1:0] num_planes;
    logic [WIDTH_W-1:0]  width_words;
    logic [HEIGHT_W-1:0] height_rows;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PIXEL_W-1:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic [WCNT_W-1:0]  word;
    logic [COL_W-1:0]   column;
    logic               half;
    phase_t             phase;
    logic [LOAD_CW-1:0] row_base;
  } pos_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
    status_t              status;
  } res_t;

endpackage

FILE: rtl/core/c2p_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/c2p_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module c2p_front import c2p_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic               in_req_type,
  input  logic [PIXEL_W-1:0] in_pixel_index,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop,
  output logic [TOTAL_W-1:0] total
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  cmd_t            q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]    count_r, count_nxt;
  logic            push_ok;
  logic            pop_ok;
  logic            geo_bad;
  logic [WIDTH_W+HEIGHT_W-1:0] area_words;
  cmd_t            cmd_in;

  // Image size in pixels
  assign area_words = (WIDTH_W+HEIGHT_W)'(cfg.width_words) *
                      (WIDTH_W+HEIGHT_W)'(cfg.height_rows);
  assign total      = {area_words, {BIT_IDX_W{1'b0}}};

  // Geometry check for the current mode
  always_comb begin
    geo_bad = 1'b0;
    if (cfg.mode != MODE_PLANES && cfg.mode != MODE_SPRITE && cfg.mode != MODE_PAIR) begin
      geo_bad = 1'b1;
    end else if (cfg.width_words == '0 || cfg.width_words > WIDTH_W'(WORD_BITS)) begin
      geo_bad = 1'b1;
    end else if (cfg.height_rows == '0) begin
      geo_bad = 1'b1;
    end else if (total > TOTAL_W'(STORE_PIXELS)) begin
      geo_bad = 1'b1;
    end else if (cfg.mode == MODE_PLANES) begin
      geo_bad = (cfg.num_planes == '0) || (cfg.num_planes > PLANES_W'(MAX_PLANES));
    end else begin
      geo_bad = cfg.width_words[0];
    end
  end

  // Classify the incoming beat
  always_comb begin
    cmd_in.pixel = in_pixel_index;
    if (in_req_type == REQ_LOAD) begin
      cmd_in.kind = CMD_LOAD;
    end else if (geo_bad) begin
      cmd_in.kind = CMD_FETCH_BAD;
    end else begin
      cmd_in.kind = CMD_FETCH;
    end
  end

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_ok && pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/c2p_back.sv
// Back end: executes queued loads and fetches against the pixel store, queues results.
module c2p_back import c2p_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               cfg_restart,
  input  logic [TOTAL_W-1:0] total,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output res_t               res
);

  localparam pos_t POS_START = '{
    plane: '0, row: '0, word: '0, column: '0, half: 1'b0, phase: PH_HEAD, row_base: '0
  };

  back_state_t          state_r, state_nxt;
  pos_t                 pos_r, pos_nxt, pos_adv;
  logic                 adv_last;
  logic [LOAD_CW-1:0]   load_count_r, load_count_nxt;
  logic [STORE_AW-1:0]  start_r, start_nxt;
  logic [2:0]           shift_r, shift_nxt;
  logic [GATHER_CW-1:0] cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;

  logic [WCNT_W:0]      word_inc;
  logic [ROW_W:0]       row_inc;
  logic [PLANE_W:0]     plane_inc;
  logic [COL_W:0]       col_inc;
  logic [LOAD_CW-1:0]   row_step;
  logic [LOAD_CW-1:0]   start_sum;
  logic [LOAD_CW-1:0]   offset;

  logic                 store_room;
  logic                 incomplete;
  logic                 gather_needed;
  logic                 gather_go;
  logic                 out_room;
  logic                 do_restart;
  logic                 load_inc;
  logic                 commit;
  logic                 start_gather;
  logic                 res_push;
  res_t                 res_in;

  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_raddr;
  logic [PIXEL_W-1:0]   ram_rdata;

  res_t                 oq_r [2];
  logic                 oq_wr_r, oq_rd_r;
  logic [1:0]           oq_cnt_r, oq_cnt_nxt;
  logic                 oq_pop;

  // Pixel store
  c2p_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count_r[STORE_AW-1:0]),
    .wdata (cmd.pixel),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign store_room    = load_count_r < LOAD_CW'(STORE_PIXELS);
  assign incomplete    = TOTAL_W'(load_count_r) < total;
  assign gather_needed = (cfg.mode == MODE_PLANES) || (pos_r.phase == PH_BODY);
  assign out_room      = (oq_cnt_r != 2'd2);
  assign gather_go     = (state_r == BK_IDLE) && cmd_valid && out_room &&
                         (cmd.kind == CMD_FETCH) && !incomplete && gather_needed;

  // Step the output position by one word
  always_comb begin
    word_inc  = {1'b0, pos_r.word} + 1'b1;
    row_inc   = {1'b0, pos_r.row} + 1'b1;
    plane_inc = {1'b0, pos_r.plane} + 1'b1;
    col_inc   = {1'b0, pos_r.column} + 1'b1;
    row_step  = LOAD_CW'({cfg.width_words, {BIT_IDX_W{1'b0}}});
    pos_adv   = pos_r;
    adv_last  = 1'b0;
    if (cfg.mode == MODE_PLANES) begin
      adv_last = (plane_inc == cfg.num_planes) &&
                 (row_inc == {1'b0, cfg.height_rows}) &&
                 (word_inc == cfg.width_words);
      pos_adv.word = word_inc[WCNT_W-1:0];
      if (word_inc == cfg.width_words) begin
        pos_adv.word     = '0;
        pos_adv.row      = row_inc[ROW_W-1:0];
        pos_adv.row_base = pos_r.row_base + row_step;
        if (row_inc == {1'b0, cfg.height_rows}) begin
          pos_adv.row      = '0;
          pos_adv.row_base = '0;
          pos_adv.plane    = plane_inc[PLANE_W-1:0];
        end
      end
    end else begin
      pos_adv.word = word_inc[WCNT_W-1:0];
      case (pos_r.phase)
        PH_HEAD: begin
          if (word_inc == (WCNT_W+1)'(EDGE_WORDS)) begin
            pos_adv.word  = '0;
            pos_adv.phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (word_inc == (WCNT_W+1)'(BODY_ROW_WORDS)) begin
            pos_adv.word     = '0;
            pos_adv.row      = row_inc[ROW_W-1:0];
            pos_adv.row_base = pos_r.row_base + row_step;
            if (row_inc == {1'b0, cfg.height_rows}) begin
              pos_adv.row      = '0;
              pos_adv.row_base = '0;
              pos_adv.phase    = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          adv_last = (word_inc == (WCNT_W+1)'(EDGE_WORDS)) &&
                     ((cfg.mode == MODE_SPRITE) || pos_r.half) &&
                     (col_inc == cfg.width_words[WIDTH_W-1:1]);
          if (word_inc == (WCNT_W+1)'(EDGE_WORDS)) begin
            pos_adv.word  = '0;
            pos_adv.phase = PH_HEAD;
            if ((cfg.mode == MODE_PAIR) && !pos_r.half) begin
              pos_adv.half = 1'b1;
            end else begin
              pos_adv.half   = 1'b0;
              pos_adv.column = col_inc[COL_W-1:0];
            end
          end
        end
        default: begin
          pos_adv = pos_r;
        end
      endcase
    end
  end

  // First pixel and bit of the word to gather
  always_comb begin
    if (cfg.mode == MODE_PLANES) begin
      offset    = LOAD_CW'({pos_r.word, {BIT_IDX_W{1'b0}}});
      shift_nxt = pos_r.plane;
    end else begin
      offset    = LOAD_CW'({pos_r.column, pos_r.word[0], {BIT_IDX_W{1'b0}}});
      shift_nxt = {1'b0, pos_r.half, pos_r.word[1]};
    end
    start_sum = pos_r.row_base + offset;
    start_nxt = start_sum[STORE_AW-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (gather_go) begin
          state_nxt = BK_GATHER;
        end
      end
      BK_GATHER: begin
        if (cnt_r == GATHER_CW'(WORD_BITS)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs per state
  always_comb begin
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    load_inc     = 1'b0;
    do_restart   = 1'b0;
    commit       = 1'b0;
    start_gather = 1'b0;
    res_push     = 1'b0;
    res_in       = '{word: '0, last: 1'b0, status: ST_OK};
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && (cmd.kind == CMD_LOAD || out_room)) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_LOAD: begin
              ram_we     = store_room;
              load_inc   = store_room;
              do_restart = 1'b1;
            end
            CMD_FETCH_BAD: begin
              res_push      = 1'b1;
              res_in.status = ST_BAD_GEOMETRY;
            end
            CMD_FETCH: begin
              if (incomplete) begin
                res_push      = 1'b1;
                res_in.status = ST_LOAD_INCOMPLETE;
              end else if (gather_needed) begin
                start_gather = 1'b1;
              end else begin
                res_push    = 1'b1;
                res_in.last = adv_last;
                commit      = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_GATHER: begin
        if (cnt_r == GATHER_CW'(WORD_BITS)) begin
          res_push    = 1'b1;
          res_in.word = acc_nxt;
          res_in.last = adv_last;
          commit      = 1'b1;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Gather datapath: one store read per pixel
  assign ram_raddr = start_r + STORE_AW'(cnt_r[BIT_IDX_W-1:0]);
  assign acc_nxt   = {acc_r[WORD_BITS-2:0], ram_rdata[shift_r]};

  always_comb begin
    cnt_nxt = cnt_r;
    if (start_gather) begin
      cnt_nxt = '0;
    end else if (state_r == BK_GATHER) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Position and load count update
  always_comb begin
    pos_nxt        = pos_r;
    load_count_nxt = load_count_r;
    if (cfg_restart || do_restart) begin
      pos_nxt = POS_START;
    end else if (commit) begin
      pos_nxt = adv_last ? POS_START : pos_adv;
    end
    if (commit && adv_last) begin
      load_count_nxt = '0;
    end else if (load_inc) begin
      load_count_nxt = load_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      pos_r        <= POS_START;
      load_count_r <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      load_count_r <= load_count_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Hold gather operands and accumulate bits
  always_ff @(posedge clk) begin
    if (start_gather) begin
      start_r <= start_nxt;
      shift_r <= shift_nxt;
    end
    if (state_r == BK_GATHER && cnt_r != '0) begin
      acc_r <= acc_nxt;
    end
  end

  // Two-entry result queue
  assign empty  = (oq_cnt_r == 2'd0);
  assign res    = oq_r[oq_rd_r];
  assign oq_pop = pop && !empty;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (res_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (!res_push && oq_pop) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (res_push) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wr_r] <= res_in;
    end
  end

endmodule

FILE: rtl/core/chunky_to_planar_converter_unit.sv
// A load is written to the store when the idle back end takes its beat; a status-only or
// blank word is queued as a result then, a gathered word once its reads end. Throughput:
// one load per cycle while no gather runs; a gather holds off other beats until its word
// is done, set by the single byte-wide read port of the pixel store (one read per pixel,
// 32 per word). Reset: registers return to mode 0, 8 planes, 10 words, 256 rows; counters
// and queues clear at once. The pixel store is not cleared: only loaded entries are read.
module chunky_to_planar_converter_unit import c2p_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_req_type,
  input  logic [PIXEL_W-1:0]    in_pixel_index,
  output logic                  empty,
  input  logic                  pop,
  output logic [WORD_BITS-1:0]  out_word,
  output logic                  out_last_word,
  output logic [1:0]            out_status
);

  localparam cfg_t CFG_RESET = '{
    mode: MODE_PLANES, num_planes: 4'd8, width_words: 6'd10, height_rows: 11'd256
  };

  cfg_t               cfg_r, cfg_nxt;
  logic               cfg_restart;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic [TOTAL_W-1:0] total;
  res_t               res;

  // Register write decode
  always_comb begin
    cfg_nxt     = cfg_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: begin
          cfg_nxt.mode = cfg_wdata[MODE_W-1:0];
          cfg_restart  = 1'b1;
        end
        CFG_PLANES: begin
          cfg_nxt.num_planes = cfg_wdata[PLANES_W-1:0];
          cfg_restart        = 1'b1;
        end
        CFG_WIDTH: begin
          cfg_nxt.width_words = cfg_wdata[WIDTH_W-1:0];
          cfg_restart         = 1'b1;
        end
        CFG_HEIGHT: begin
          cfg_nxt.height_rows = cfg_wdata[HEIGHT_W-1:0];
          cfg_restart         = 1'b1;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  c2p_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_pixel_index (in_pixel_index),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .total          (total)
  );

  c2p_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cfg_restart (cfg_restart),
    .total       (total),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res         (res)
  );

  assign out_word      = res.word;
  assign out_last_word = res.last;
  assign out_status    = res.status;

endmodule
